### hw/rtl/psi_pkg.sv
package psi_pkg;

	// Array and accumulator sizing.
	localparam int CHANNELS = 512;
	localparam int SUM_BITS = 64;
	localparam int CH_W = $clog2(CHANNELS);

	// Fixed field widths and number formats.
	localparam int Q_W = 48;
	localparam int FRAME_W = 32;
	localparam int CNT_W = FRAME_W + 1;
	localparam int GAIN_W = 24;
	localparam int GAIN_FRAC = 16;
	localparam int MANT_W = 24;
	localparam int EXP_W = 7;
	localparam int EXP_ZERO = 64;
	localparam int PROD_W = 32 + GAIN_W;
	localparam logic [Q_W-1:0] Q48_MAX = '1;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

	// Request operation codes.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH_RD,
		ST_PUSH_WR,
		ST_READ_RD,
		ST_READ_CHK,
		ST_READ_DIV,
		ST_READ_MUL,
		ST_READ_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [31:0] sample_word;
		logic [8:0] read_channel;
	} req_t;

	typedef struct packed {
		logic [8:0] channel_index;
		logic [Q_W-1:0] mean_value;
		logic channel_empty;
		logic saturated;
	} res_t;

endpackage

### hw/rtl/psi_conv.sv
module psi_conv (
	input logic clk,
	input logic en,
	input logic [31:0] word,
	output logic [psi_pkg::Q_W-1:0] value_s1
);

	logic [psi_pkg::MANT_W-1:0] mant;
	logic [psi_pkg::EXP_W-1:0] expo;
	logic [psi_pkg::EXP_W-1:0] dn_sh;
	logic [psi_pkg::EXP_W-1:0] up_sh;
	logic [psi_pkg::Q_W+psi_pkg::MANT_W-1:0] up;
	logic [psi_pkg::Q_W-1:0] value;

	// Split the word; bit 31 carries no meaning.
	assign mant = word[psi_pkg::MANT_W-1:0];
	assign expo = word[30:24];
	assign dn_sh = psi_pkg::EXP_W'(psi_pkg::EXP_ZERO) - expo;
	assign up_sh = expo - psi_pkg::EXP_W'(psi_pkg::EXP_ZERO);
	assign up = (psi_pkg::Q_W+psi_pkg::MANT_W)'(mant) << up_sh;

	// Small values truncate below the LSB, large values clip at the Q24.24 ceiling.
	always_comb begin
		if (expo < psi_pkg::EXP_W'(psi_pkg::EXP_ZERO)) begin
			value = psi_pkg::Q_W'(mant >> dn_sh);
		end else if (mant == '0) begin
			value = '0;
		end else if (up_sh >= psi_pkg::EXP_W'(psi_pkg::Q_W)
				|| up[psi_pkg::Q_W+psi_pkg::MANT_W-1:psi_pkg::Q_W] != '0) begin
			value = psi_pkg::Q48_MAX;
		end else begin
			value = up[psi_pkg::Q_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s1 <= value;
		end
	end

endmodule

### hw/rtl/psi_div.sv
module psi_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [psi_pkg::SUM_BITS-1:0] dividend,
	input logic [psi_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic [psi_pkg::SUM_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(psi_pkg::SUM_BITS + 1);

	logic [psi_pkg::SUM_BITS-1:0] num_q;
	logic [psi_pkg::CNT_W-1:0] den_q;
	logic [psi_pkg::CNT_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic run_q;
	logic done_q;
	logic [psi_pkg::CNT_W:0] shifted;
	logic [psi_pkg::CNT_W:0] diff;
	logic fits;

	// One restoring step: bring in the next dividend bit and try the subtract.
	assign shifted = {rem_q, num_q[psi_pkg::SUM_BITS-1]};
	assign diff = shifted - {1'b0, den_q};
	assign fits = !diff[psi_pkg::CNT_W];

	// Control state of the bit-serial loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= STEP_W'(psi_pkg::SUM_BITS);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				run_q <= step_q != STEP_W'(1);
				done_q <= step_q == STEP_W'(1);
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Dividend bits shift out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[psi_pkg::SUM_BITS-2:0], fits};
			rem_q <= fits ? diff[psi_pkg::CNT_W-1:0] : shifted[psi_pkg::CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = num_q;

endmodule

### hw/rtl/psi_scale.sv
module psi_scale (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [psi_pkg::SUM_BITS-1:0] mean,
	input logic [psi_pkg::GAIN_W-1:0] gain,
	output logic done,
	output logic [psi_pkg::Q_W-1:0] value,
	output logic sat
);

	logic [2:0] phase_q;
	logic [psi_pkg::SUM_BITS-1:0] mean_q;
	logic [psi_pkg::PROD_W-1:0] lo_q;
	logic [psi_pkg::PROD_W-1:0] hi_q;
	logic [psi_pkg::Q_W-1:0] value_q;
	logic sat_q;
	logic [31:0] opnd;
	logic [psi_pkg::PROD_W-1:0] prod;
	logic [psi_pkg::Q_W:0] total;
	logic hi_big;

	// One 32x24 multiplier serves the low half, then the high half of the mean.
	assign opnd = phase_q[0] ? mean_q[31:0] : 32'(mean_q[psi_pkg::SUM_BITS-1:32]);
	assign prod = opnd * gain;

	// Recombine the halves, dropping the gain fraction.
	assign hi_big = hi_q[psi_pkg::PROD_W-1:32] != '0;
	assign total = {1'b0, hi_q[31:0], {psi_pkg::GAIN_FRAC{1'b0}}}
		+ (psi_pkg::Q_W+1)'(lo_q[psi_pkg::PROD_W-1:psi_pkg::GAIN_FRAC]);

	// Phase marks walk through the three steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else begin
			phase_q <= {phase_q[1:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mean_q <= mean;
		end
		if (phase_q[0]) begin
			lo_q <= prod;
		end
		if (phase_q[1]) begin
			hi_q <= prod;
		end
		if (phase_q[2]) begin
			if (hi_big || total >= {1'b0, psi_pkg::Q48_MAX}) begin
				value_q <= psi_pkg::Q48_MAX;
				sat_q <= 1'b1;
			end else begin
				value_q <= total[psi_pkg::Q_W-1:0];
				sat_q <= 1'b0;
			end
		end
	end

	// Done is registered together with the final step, so it rises as the result appears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= phase_q[2];
		end
	end

	assign value = value_q;
	assign sat = sat_q;

endmodule

### hw/rtl/per_channel_spectrum_integrator.sv
// Channel      Signals                            Moves
// request      start, busy, request               push, read or clear, taken at start & !busy
// result       result_valid, result               one mean per read, strobed for one cycle
// config       cfg_we, cfg_wdata                  gain register, written at once
//
// Busy after the accepting edge: a push steps through a memory read with conversion,
// then add and write back through the single port; a read of an empty channel steps
// through the memory read, check and output states, otherwise through the memory read,
// check, the SUM_BITS divider steps and its done, the shared multiplier and the output.
// A clear, and reset, sweep the sum memory one entry a cycle, with busy high throughout.
// The receiver cannot stall; every result is presented for exactly one cycle.
module per_channel_spectrum_integrator (
	input logic clk,
	input logic arst_n,
	input logic start,
	input psi_pkg::req_t request,
	output logic busy,
	input logic cfg_we,
	input logic [psi_pkg::GAIN_W-1:0] cfg_wdata,
	output logic result_valid,
	output psi_pkg::res_t result
);

	localparam int MEM_W = psi_pkg::SUM_BITS + 1;

	psi_pkg::state_t state_q;
	psi_pkg::state_t state_d;
	psi_pkg::req_t req_q;
	logic [psi_pkg::CH_W-1:0] next_ch_q;
	logic [psi_pkg::FRAME_W-1:0] frame_q;
	logic [psi_pkg::CH_W-1:0] clr_q;
	logic [psi_pkg::GAIN_W-1:0] gain_q;
	logic [MEM_W-1:0] mem_q [psi_pkg::CHANNELS];
	logic [MEM_W-1:0] rdata_q;
	logic present_q;
	logic empty_q;

	logic accept;
	logic mem_we;
	logic mem_re;
	logic [psi_pkg::CH_W-1:0] mem_addr;
	logic [MEM_W-1:0] mem_wdata;
	logic conv_en;
	logic div_start;
	logic scale_start;
	logic [psi_pkg::Q_W-1:0] conv_s1;
	logic [psi_pkg::SUM_BITS:0] sum_full;
	logic ovf;
	logic [psi_pkg::CH_W-1:0] rd_addr;
	logic present;
	logic below;
	logic [psi_pkg::CNT_W-1:0] count;
	logic empty;
	logic div_done;
	logic [psi_pkg::SUM_BITS-1:0] quotient;
	logic scale_done;
	logic [psi_pkg::Q_W-1:0] scale_value;
	logic scale_sat;

	assign accept = start && !busy;

	// Saturating accumulate of the converted sample.
	assign sum_full = {1'b0, rdata_q[psi_pkg::SUM_BITS-1:0]}
		+ {{(psi_pkg::SUM_BITS+1-psi_pkg::Q_W){1'b0}}, conv_s1};
	assign ovf = sum_full[psi_pkg::SUM_BITS];

	// Sample count of the requested channel.
	assign rd_addr = psi_pkg::CH_W'(req_q.read_channel);
	assign present = 32'(req_q.read_channel) < 32'(psi_pkg::CHANNELS);
	assign below = rd_addr < next_ch_q;
	assign count = {1'b0, frame_q} + psi_pkg::CNT_W'(below);
	assign empty = !present || count == '0;

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			psi_pkg::ST_CLEAR: begin
				if (clr_q == psi_pkg::CH_W'(psi_pkg::CHANNELS - 1)) begin
					state_d = psi_pkg::ST_IDLE;
				end
			end
			psi_pkg::ST_IDLE: begin
				if (start) begin
					case (request.opcode)
						psi_pkg::OP_PUSH: state_d = psi_pkg::ST_PUSH_RD;
						psi_pkg::OP_READ: state_d = psi_pkg::ST_READ_RD;
						psi_pkg::OP_CLEAR: state_d = psi_pkg::ST_CLEAR;
						default: state_d = psi_pkg::ST_IDLE;
					endcase
				end
			end
			psi_pkg::ST_PUSH_RD: state_d = psi_pkg::ST_PUSH_WR;
			psi_pkg::ST_PUSH_WR: state_d = psi_pkg::ST_IDLE;
			psi_pkg::ST_READ_RD: state_d = psi_pkg::ST_READ_CHK;
			psi_pkg::ST_READ_CHK: begin
				state_d = empty ? psi_pkg::ST_READ_OUT : psi_pkg::ST_READ_DIV;
			end
			psi_pkg::ST_READ_DIV: begin
				if (div_done) begin
					state_d = psi_pkg::ST_READ_MUL;
				end
			end
			psi_pkg::ST_READ_MUL: begin
				if (scale_done) begin
					state_d = psi_pkg::ST_READ_OUT;
				end
			end
			psi_pkg::ST_READ_OUT: state_d = psi_pkg::ST_IDLE;
			default: state_d = psi_pkg::ST_IDLE;
		endcase
	end

	// Output decode of the sequencer: memory port, unit starts and handshake.
	always_comb begin
		busy = 1'b1;
		result_valid = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = next_ch_q;
		mem_wdata = '0;
		conv_en = 1'b0;
		div_start = 1'b0;
		scale_start = 1'b0;
		case (state_q)
			psi_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
			end
			psi_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			psi_pkg::ST_PUSH_RD: begin
				mem_re = 1'b1;
				conv_en = 1'b1;
			end
			psi_pkg::ST_PUSH_WR: begin
				mem_we = 1'b1;
				mem_wdata = {rdata_q[psi_pkg::SUM_BITS] | ovf,
					ovf ? {psi_pkg::SUM_BITS{1'b1}} : sum_full[psi_pkg::SUM_BITS-1:0]};
			end
			psi_pkg::ST_READ_RD: begin
				mem_re = 1'b1;
				mem_addr = rd_addr;
			end
			psi_pkg::ST_READ_CHK: begin
				div_start = !empty;
			end
			psi_pkg::ST_READ_DIV: begin
				scale_start = div_done;
			end
			psi_pkg::ST_READ_MUL: begin
			end
			psi_pkg::ST_READ_OUT: begin
				result_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result fields, held in registers while the read finishes.
	always_comb begin
		result.channel_index = req_q.read_channel;
		result.mean_value = empty_q ? '0 : scale_value;
		result.channel_empty = empty_q;
		result.saturated = (present_q && rdata_q[psi_pkg::SUM_BITS]) || (!empty_q && scale_sat);
	end

	// Sequencer, position and frame counters, clear sweep and gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psi_pkg::ST_CLEAR;
			next_ch_q <= '0;
			frame_q <= '0;
			clr_q <= '0;
			gain_q <= psi_pkg::GAIN_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			if (accept && request.opcode == psi_pkg::OP_CLEAR) begin
				clr_q <= '0;
				next_ch_q <= '0;
				frame_q <= '0;
			end else if (state_q == psi_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else if (state_q == psi_pkg::ST_PUSH_WR) begin
				if (next_ch_q == psi_pkg::CH_W'(psi_pkg::CHANNELS - 1)) begin
					next_ch_q <= '0;
					if (frame_q != '1) begin
						frame_q <= frame_q + 1'b1;
					end
				end else begin
					next_ch_q <= next_ch_q + 1'b1;
				end
			end
		end
	end

	// Request capture and read status flags.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (state_q == psi_pkg::ST_READ_CHK) begin
			present_q <= present;
			empty_q <= empty;
		end
	end

	// Sum memory with the overflow mark in its top bit; one port, registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	psi_conv u_conv (
		.clk(clk),
		.en(conv_en),
		.word(req_q.sample_word),
		.value_s1(conv_s1)
	);

	psi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(rdata_q[psi_pkg::SUM_BITS-1:0]),
		.divisor(count),
		.done(div_done),
		.quotient(quotient)
	);

	psi_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.start(scale_start),
		.mean(quotient),
		.gain(gain_q),
		.done(scale_done),
		.value(scale_value),
		.sat(scale_sat)
	);

endmodule

### dv/per_channel_spectrum_integrator_tb.sv
module per_channel_spectrum_integrator_tb;
	import psi_pkg::*;

	// Opcode that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Wait long enough to cover a clear sweep or the slowest read.
	localparam int SETTLE_CYCLES = CHANNELS + SUM_BITS + 16;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_REQUESTS = 138;

	typedef struct packed {
		req_t rq;
		logic literal;
		res_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	logic cfg_we;
	logic [GAIN_W-1:0] cfg_wdata;
	logic result_valid;
	res_t result;

	// Predicted block state.
	logic [SUM_BITS-1:0] chan_sum [CHANNELS];
	logic chan_sat_mark [CHANNELS];
	int model_next_chan;
	logic [FRAME_W-1:0] model_frames;
	logic [GAIN_W-1:0] model_gain;

	res_t pending_means [$];
	res_t res_seen;
	int fail_count = 0;

	// Directed requests. Rows with literal set carry a result that is plain by inspection.
	row_t dir_rows [25] = '{
		'{'{OP_READ,   32'h0000_0000, 9'd0},   1'b1, '{9'd0, 48'd0, 1'b1, 1'b0}},
		'{'{OP_READ,   32'hFFFF_FFFF, 9'd511}, 1'b1, '{9'd511, 48'd0, 1'b1, 1'b0}},
		'{'{OP_PUSH,   32'h40FF_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_READ,   32'h0000_0000, 9'd0},   1'b1, '{9'd0, 48'hFF_FFFF, 1'b0, 1'b0}},
		'{'{OP_PUSH,   32'hFFFF_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_READ,   32'h0000_0000, 9'd1},   1'b1, '{9'd1, Q48_MAX, 1'b0, 1'b1}},
		'{'{OP_PUSH,   32'h0000_0000, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h8000_0001, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h28FF_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h29FF_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h5800_0001, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h59FF_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h597F_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h7000_0001, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h6F00_0001, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h7F00_0000, 9'd0},   1'b0, '0},
		'{'{OP_PUSH,   32'h3F00_0003, 9'd0},   1'b0, '0},
		'{'{OP_READ,   32'h0000_0000, 9'd13},  1'b1, '{9'd13, 48'd0, 1'b1, 1'b0}},
		'{'{OP_READ,   32'h0000_0000, 9'd5},   1'b0, '0},
		'{'{OP_READ,   32'h0000_0000, 9'd8},   1'b0, '0},
		'{'{OP_READ,   32'h0000_0000, 9'd10},  1'b0, '0},
		'{'{OP_UNUSED, 32'hFFFF_FFFF, 9'd0},   1'b0, '0},
		'{'{OP_CLEAR,  32'h0000_0000, 9'd0},   1'b0, '0},
		'{'{OP_READ,   32'h0000_0000, 9'd1},   1'b1, '{9'd1, 48'd0, 1'b1, 1'b0}},
		'{'{OP_PUSH,   32'h4C12_3456, 9'd0},   1'b0, '0}
	};

	per_channel_spectrum_integrator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Convert a raw spectrometer word to unsigned Q24.24, truncating and saturating.
	function automatic logic [Q_W-1:0] q24_from_word(input logic [31:0] word);
		logic [MANT_W-1:0] mant;
		logic [EXP_W-1:0] expo;
		int sh;
		logic [63:0] wide;
		mant = word[23:0];
		expo = word[30:24];
		if (expo < EXP_ZERO) begin
			sh = EXP_ZERO - int'(expo);
			if (sh >= 24)
				return '0;
			return Q_W'(mant >> sh);
		end
		sh = int'(expo) - EXP_ZERO;
		if (mant == '0)
			return '0;
		if (sh >= 48)
			return Q48_MAX;
		if (sh > 24 && (mant >> (48 - sh)) != '0)
			return Q48_MAX;
		wide = 64'(mant) << sh;
		return wide[Q_W-1:0];
	endfunction

	// Return the block to its post-clear state; the gain is kept.
	task automatic clear_integrator();
		for (int i = 0; i < CHANNELS; i++) begin
			chan_sum[i] = '0;
			chan_sat_mark[i] = 1'b0;
		end
		model_next_chan = 0;
		model_frames = '0;
	endtask

	// Advance the predicted state by one request and give the mean it returns, if any.
	task automatic integrate_request(input req_t rq, output logic produces, output res_t res);
		logic [SUM_BITS:0] total;
		logic [CNT_W-1:0] count;
		logic [63:0] quot;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] scaled;
		int ch;
		produces = 1'b0;
		res = '0;
		case (rq.opcode)
			OP_PUSH: begin
				ch = model_next_chan;
				total = {1'b0, chan_sum[ch]} + (SUM_BITS + 1)'(q24_from_word(rq.sample_word));
				if (total[SUM_BITS]) begin
					chan_sum[ch] = '1;
					chan_sat_mark[ch] = 1'b1;
				end else begin
					chan_sum[ch] = total[SUM_BITS-1:0];
				end
				if (ch == CHANNELS - 1) begin
					model_next_chan = 0;
					if (model_frames != '1)
						model_frames++;
				end else begin
					model_next_chan = ch + 1;
				end
			end
			OP_CLEAR: begin
				clear_integrator();
			end
			OP_READ: begin
				produces = 1'b1;
				ch = int'(rq.read_channel);
				res.channel_index = rq.read_channel;
				res.channel_empty = 1'b1;
				if (ch < CHANNELS) begin
					count = CNT_W'(model_frames) + CNT_W'(ch < model_next_chan);
					res.saturated = chan_sat_mark[ch];
					if (count != '0) begin
						res.channel_empty = 1'b0;
						quot = 64'(chan_sum[ch]) / 64'(count);
						hi = 64'(quot[63:32]) * 64'(model_gain);
						lo = 64'(quot[31:0]) * 64'(model_gain);
						if (hi > 64'(Q48_MAX >> GAIN_FRAC)) begin
							res.mean_value = Q48_MAX;
							res.saturated = 1'b1;
						end else begin
							scaled = (hi << GAIN_FRAC) + (lo >> GAIN_FRAC);
							if (scaled >= 64'(Q48_MAX)) begin
								res.mean_value = Q48_MAX;
								res.saturated = 1'b1;
							end else begin
								res.mean_value = scaled[Q_W-1:0];
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// Present one request from the falling edge until the block takes it.
	task automatic send_request(input req_t rq, input logic literal, input res_t lit_res);
		logic produces;
		res_t predicted;
		@(negedge clk);
		start = 1'b1;
		request = rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		integrate_request(rq, produces, predicted);
		if (produces)
			pending_means = {pending_means, (literal ? lit_res : predicted)};
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// Hold off new requests until every pending mean has come back.
	task automatic drain_means();
		idle_cycles(1);
		while (pending_means.size() != 0)
			@(posedge clk);
	endtask

	// Write the gain only once the block has gone quiet.
	task automatic set_gain(input logic [GAIN_W-1:0] gain);
		drain_means();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = gain;
		@(negedge clk);
		cfg_we = 1'b0;
		model_gain = gain;
	endtask

	// Sample words biased toward exponents near the Q24.24 window.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return {1'($urandom), 7'($urandom_range(40, 100)), 24'($urandom)};
			default: return {1'($urandom), 7'($urandom_range(56, 72)), 24'($urandom_range(0, 4095))};
		endcase
	endfunction

	// Mostly pushes, with reads, rare clears and the odd unused opcode.
	function automatic req_t random_request();
		int pick;
		req_t rq;
		pick = $urandom_range(0, 999);
		rq.sample_word = random_word();
		if ($urandom_range(0, 1) == 1 && model_next_chan > 0)
			rq.read_channel = 9'($urandom_range(0, model_next_chan - 1));
		else
			rq.read_channel = 9'($urandom);
		if (pick < 5)
			rq.opcode = OP_CLEAR;
		else if (pick < 15)
			rq.opcode = OP_UNUSED;
		else if (pick < 200)
			rq.opcode = OP_READ;
		else
			rq.opcode = OP_PUSH;
		return rq;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compare every strobed mean with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected mean: expected none, actual %h", $time, result);
				fail_count++;
			end else begin
				res_seen = pending_means.pop_front();
				check_field("channel_index", 64'(res_seen.channel_index), 64'(result.channel_index));
				check_field("mean_value", 64'(res_seen.mean_value), 64'(result.mean_value));
				check_field("channel_empty", 64'(res_seen.channel_empty), 64'(result.channel_empty));
				check_field("saturated", 64'(res_seen.saturated), 64'(result.saturated));
			end
		end
	end

	// Stimulus: directed rows, then random segments under varying gain and idling.
	initial begin
		logic [GAIN_W-1:0] seg_gains [SEGMENTS];
		int idle_pct;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		model_gain = GAIN_RESET;
		clear_integrator();
		seg_gains = '{24'hFF_FFFF, 24'd0, 24'($urandom), 24'd1, 24'($urandom), GAIN_RESET};
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].rq, dir_rows[i].literal, dir_rows[i].want);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			set_gain(seg_gains[seg]);
			idle_pct = (seg < 2) ? 7 : (seg < 4) ? 51 : 0;
			repeat (SEGMENT_REQUESTS) begin
				// Each cycle where a request could go out is left idle with this chance.
				while ($urandom_range(0, 99) < idle_pct)
					idle_cycles(1);
				if ($urandom_range(0, 99) == 0)
					drain_means();
				send_request(random_request(), 1'b0, '0);
			end
		end

		drain_means();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (pending_means.size() != 0) begin
			$display("%0t: %0d means never returned, oldest expected %h", $time,
				pending_means.size(), pending_means[0]);
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#6000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
